FILE: sv/chbm_pkg.sv
package chbm_pkg;

  localparam int CHANNELS_DEF    = 32;
  localparam int BUTTON_BITS_DEF = 64;

  localparam logic [7:0] HOLD_RESET = 8'd20;

  localparam logic signed [12:0] VALUE_OFFSET = 13'sd1024;
  localparam logic [10:0] VALUE_MAX = 11'd2047;
  localparam logic [10:0] VALUE_MID = 11'd1024;

  localparam logic [2:0] MODE_NORMAL    = 3'd0;
  localparam logic [2:0] MODE_PULSE     = 3'd1;
  localparam logic [2:0] MODE_SWITCH    = 3'd2;
  localparam logic [2:0] MODE_DELTA     = 3'd3;
  localparam logic [2:0] MODE_COMPANION = 3'd4;

  typedef struct packed {
    logic       running;
    logic [7:0] start;
    logic [4:0] level;
  } entry_t;

  // width of one quantizing step, 2048 / positions rounded down, for 2 to 8 positions
  function automatic logic [10:0] step_of(input logic [3:0] npos);
    logic [10:0] s;
    case (npos)
      4'd2:    s = 11'd1024;
      4'd3:    s = 11'd682;
      4'd4:    s = 11'd512;
      4'd5:    s = 11'd409;
      4'd6:    s = 11'd341;
      4'd7:    s = 11'd292;
      4'd8:    s = 11'd256;
      default: s = 11'd1024;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/chbm_ram.sv
module chbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/channel_to_button_mapper_core.sv
// Channel to button mapper.
// Slave stream: one request per channel update. Master stream: one result per
// request, carrying the full button bitmap, the quantized level and a changed
// flag. cfg_we_i/cfg_wdata_i write the pulse hold time in ticks, while idle.
// Each request is handled in steps: the accept cycle issues the read of the
// per-channel entry from the channel RAM, the next cycle quantizes the value,
// the write-back step does the read-modify-write of the entry and the bitmap and
// loads the output register. A new request is not taken before the write-back
// of the last one, set by the single RAM read and write-back per request; the
// next request is accepted in the cycle after the write-back.
// The output register holds the result until taken; a new request is still
// accepted meanwhile and waits at the write-back step while the receiver
// stalls.
// Reset clears the bitmap, the hold time (to 20) and the per-channel seen
// flags at once; an unseen channel reads as all zeros, so no clearing pass.
module channel_to_button_mapper_core
  import chbm_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int BUTTON_BITS = BUTTON_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[4:0], out_value[16:5], button_mode[19:17], first_button[25:20],
  // positions_minus_one[28:26], invert[29], now_tick[37:30], zero fill
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // button_bits[63:0], level[68:64], changed[69], zero fill
  output logic [71:0] m_axis_tdata
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = $bits(entry_t);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic [7:0] hold_q;
  logic [BUTTON_BITS-1:0] map_q, map_d;
  logic [CHANNELS-1:0] seen_q;

  logic [4:0]  ch_q;
  logic [11:0] val_q;
  logic [2:0]  mode_q;
  logic [5:0]  base_q;
  logic [2:0]  pm1_q;
  logic        inv_q;
  logic [7:0]  now_q;
  logic [4:0]  lvl_q, lvl_d;

  logic        out_valid_q;
  logic [63:0] out_bits_q;
  logic [4:0]  out_lvl_q;
  logic        out_chg_q;

  logic s_acc, fire, in_rng, seen, chg, expire, run1;
  logic [7:0] start1;
  logic [AW-1:0] addr_q;
  logic [3:0] npos;
  entry_t ent, wr_ent;
  logic [EW-1:0] rdata;
  logic [BUTTON_BITS-1:0] map1;

  function automatic logic [BUTTON_BITS-1:0] put_bits(
    input logic [BUTTON_BITS-1:0] map,
    input logic [5:0]             base,
    input logic [7:0]             pat,
    input logic [3:0]             cnt
  );
    logic [7:0] m8;
    logic [BUTTON_BITS-1:0] mask, bits;
    m8   = 8'((9'd1 << cnt) - 9'd1);
    mask = BUTTON_BITS'(m8) << base;
    bits = BUTTON_BITS'(pat & m8) << base;
    return (map & ~mask) | bits;
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign fire = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign npos = {1'b0, pm1_q} + 4'd1;
  assign addr_q = AW'(ch_q);

  chbm_ram #(.WIDTH(EW), .DEPTH(CHANNELS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (fire && in_rng),
    .waddr_i (addr_q),
    .wdata_i (wr_ent),
    .re_i    (s_acc),
    .raddr_i (AW'(s_axis_tdata[4:0])),
    .rdata_o (rdata)
  );

  // value conditioning and quantizing
  always_comb begin
    logic signed [12:0] t;
    logic [10:0] v, stp;
    logic gt, lt;
    logic [4:0] q;
    t = $signed({val_q[11], val_q}) + VALUE_OFFSET;
    if (t < 13'sd0) begin
      v = '0;
    end else if (t > $signed({2'b00, VALUE_MAX})) begin
      v = VALUE_MAX;
    end else begin
      v = t[10:0];
    end
    if (inv_q) begin
      v = VALUE_MAX - v;
    end
    gt  = v > VALUE_MID;
    lt  = v < VALUE_MID;
    stp = step_of(npos);
    q   = '0;
    for (int k = 1; k < 8; k++) begin
      if (4'(k) < npos && {3'b000, v} >= 14'(k) * {3'b000, stp}) begin
        q = q + 5'd1;
      end
    end
    if (npos == 4'd1) begin
      q = {4'b0, gt};
    end
    case (mode_q)
      MODE_NORMAL, MODE_PULSE: lvl_d = q;
      MODE_SWITCH: lvl_d = {4'b0, gt};
      MODE_DELTA: lvl_d = v[10:6];
      MODE_COMPANION: begin
        if (npos <= 4'd2) begin
          lvl_d = {4'b0, gt};
        end else if (npos == 4'd3) begin
          lvl_d = lt ? 5'd1 : (gt ? 5'd2 : 5'd0);
        end else begin
          lvl_d = q;
        end
      end
      default: lvl_d = '0;
    endcase
  end

  // read-modify-write of the channel entry and the bitmap
  always_comb begin
    logic [7:0] hot;
    in_rng = 32'(ch_q) < CHANNELS;
    seen   = in_rng && seen_q[addr_q];
    ent    = seen ? entry_t'(rdata) : '0;
    chg    = in_rng && (!seen || ent.level != lvl_q);
    hot    = 8'(9'd1 << lvl_q[2:0]);
    map1   = map_q;
    run1   = ent.running;
    start1 = ent.start;
    if (chg) begin
      case (mode_q)
        MODE_NORMAL, MODE_PULSE: begin
          if (npos == 4'd1) begin
            map1 = put_bits(map_q, base_q, {3'b0, lvl_q}, 4'd1);
          end else begin
            map1 = put_bits(map_q, base_q, hot, npos);
          end
          if (mode_q == MODE_PULSE) begin
            run1   = 1'b1;
            start1 = now_q;
          end
        end
        MODE_SWITCH: begin
          if (seen && ent.level < lvl_q) begin
            map1 = map_q ^ (BUTTON_BITS'(1) << base_q);
          end
        end
        MODE_DELTA: begin
          if (seen) begin
            if (ent.level < lvl_q) begin
              map1 = put_bits(map_q, base_q, 8'd2, 4'd2);
            end else if (ent.level > lvl_q) begin
              map1 = put_bits(map_q, base_q, 8'd1, 4'd2);
            end
            run1   = 1'b1;
            start1 = now_q;
          end
        end
        MODE_COMPANION: begin
          if (npos <= 4'd2) begin
            map1 = put_bits(map_q, base_q, {3'b0, lvl_q}, 4'd1);
          end else if (npos == 4'd3) begin
            map1 = put_bits(map_q, base_q, {3'b0, lvl_q}, 4'd2);
          end else begin
            map1 = put_bits(map_q, base_q, hot, npos);
          end
        end
        default: map1 = map_q;
      endcase
    end
    expire = in_rng && run1 && (8'(now_q - start1) >= hold_q);
    map_d  = in_rng ? map1 : map_q;
    if (expire) begin
      if (mode_q == MODE_PULSE) begin
        map_d = put_bits(map1, base_q, 8'd0, npos);
      end else if (mode_q == MODE_DELTA) begin
        map_d = put_bits(map1, base_q, 8'd0, 4'd2);
      end
    end
    wr_ent.running = run1 && !expire;
    wr_ent.start   = start1;
    wr_ent.level   = lvl_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_acc) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: if (fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hold_q      <= HOLD_RESET;
      map_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
      if (fire) begin
        map_q <= map_d;
        if (in_rng) begin
          seen_q[addr_q] <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ch_q   <= s_axis_tdata[4:0];
      val_q  <= s_axis_tdata[16:5];
      mode_q <= s_axis_tdata[19:17];
      base_q <= s_axis_tdata[25:20];
      pm1_q  <= s_axis_tdata[28:26];
      inv_q  <= s_axis_tdata[29];
      now_q  <= s_axis_tdata[37:30];
    end
    if (state_q == ST_READ) begin
      lvl_q <= lvl_d;
    end
    if (fire) begin
      out_bits_q <= 64'(map_d);
      out_lvl_q  <= lvl_q;
      out_chg_q  <= chg;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_chg_q, out_lvl_q, out_bits_q};

  a_acc_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> state_q == ST_READ)
    else $error("accepted request did not start a read");

  a_read_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_EXEC)
    else $error("read not followed by write-back");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result lost");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC && !fire |=> state_q == ST_EXEC && !s_axis_tready)
    else $error("request accepted while write-back pending");

endmodule

FILE: verif/channel_to_button_mapper_core_tb.sv
module testbench
  import chbm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS     = CHANNELS_DEF;
  localparam int BUTTON_BITS  = BUTTON_BITS_DEF;
  localparam int STALL_CYCLES = 150;
  localparam int IDLE_LIMIT   = 1000;
  localparam int PHASE_ITEMS  = 370;

  // mode codes the block does not know
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  typedef struct {
    logic [4:0]        channel;
    logic signed [11:0] out_value;
    logic [2:0]        mode;
    logic [5:0]        first_button;
    logic [2:0]        pos_m1;
    logic              invert;
    logic [7:0]        tick;
  } update_t;

  typedef struct {
    logic [63:0] buttons;
    logic [4:0]  level;
    logic        changed;
  } report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // channel[4:0], out_value[16:5], button_mode[19:17], first_button[25:20],
  // positions_minus_one[28:26], invert[29], now_tick[37:30], zero fill
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // button_bits[63:0], level[68:64], changed[69], zero fill
  logic [71:0] m_axis_tdata;

  // button map model
  logic [7:0]             hold_ticks = HOLD_RESET;
  logic [4:0]             stored_level[CHANNELS];
  logic                   level_seen[CHANNELS];
  logic                   timer_on[CHANNELS];
  logic [7:0]             timer_from[CHANNELS];
  logic [BUTTON_BITS-1:0] button_state = '0;

  report_t expected_reports[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      src_idle_pct = 0;
  int      sink_idle_pct = 0;
  logic    stall_hold = 1'b0;

  // per-channel setups for the random phases
  logic [2:0] setup_mode[CHANNELS];
  logic [5:0] setup_base[CHANNELS];
  logic [2:0] setup_pm1[CHANNELS];
  logic       setup_inv[CHANNELS];
  int         chan_first = 0;
  int         chan_span = 1;
  logic [7:0] now_tick = '0;

  channel_to_button_mapper_core #(
    .CHANNELS    (CHANNELS),
    .BUTTON_BITS (BUTTON_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [4:0] quant_level(input logic [10:0] v, input int npos);
    int q;
    if (npos == 1) return 5'(v > VALUE_MID);
    q = int'(v) / (2048 / npos);
    if (q >= npos) q = npos - 1;
    return 5'(q);
  endfunction

  function automatic void put_buttons(input int b, input int pattern, input int count);
    for (int i = 0; i < count; i++)
      if (b + i < BUTTON_BITS) button_state[b + i] = pattern[i];
  endfunction

  function automatic report_t map_update(input update_t u);
    report_t    r;
    int         sv;
    int         npos;
    int         ch;
    int         b;
    logic [10:0] v;
    logic [4:0] lvl;
    logic [4:0] old;
    logic       seen;
    ch = u.channel;
    b = u.first_button;
    npos = int'(u.pos_m1) + 1;
    sv = int'(u.out_value) + 1024;
    if (sv > 2047) sv = 2047;
    if (sv < 0) sv = 0;
    v = 11'(sv);
    if (u.invert) v = VALUE_MAX - v;
    case (u.mode)
      MODE_NORMAL, MODE_PULSE: lvl = quant_level(v, npos);
      MODE_SWITCH: lvl = 5'(v > VALUE_MID);
      MODE_DELTA: lvl = 5'(v >> 6);
      MODE_COMPANION: begin
        if (npos <= 2) lvl = 5'(v > VALUE_MID);
        else if (npos == 3) lvl = (v < VALUE_MID) ? 5'd1 : ((v > VALUE_MID) ? 5'd2 : 5'd0);
        else lvl = quant_level(v, npos);
      end
      default: lvl = 5'd0;
    endcase
    r.changed = 1'b0;
    seen = level_seen[ch];
    old = stored_level[ch];
    if (!seen || old != lvl) begin
      r.changed = 1'b1;
      case (u.mode)
        MODE_NORMAL, MODE_PULSE: begin
          if (npos == 1) put_buttons(b, int'(lvl), 1);
          else put_buttons(b, 1 << lvl, npos);
          if (u.mode == MODE_PULSE) begin
            timer_on[ch] = 1'b1;
            timer_from[ch] = u.tick;
          end
        end
        MODE_SWITCH: begin
          if (seen && old < lvl && b < BUTTON_BITS) button_state[b] = ~button_state[b];
        end
        MODE_DELTA: begin
          if (seen) begin
            if (old < lvl) put_buttons(b, 2, 2);
            else if (old > lvl) put_buttons(b, 1, 2);
            timer_on[ch] = 1'b1;
            timer_from[ch] = u.tick;
          end
        end
        MODE_COMPANION: begin
          if (npos <= 2) put_buttons(b, int'(lvl), 1);
          else if (npos == 3) put_buttons(b, int'(lvl), 2);
          else put_buttons(b, 1 << lvl, npos);
        end
        default: ;
      endcase
      stored_level[ch] = lvl;
      level_seen[ch] = 1'b1;
    end
    if (timer_on[ch] && 8'(u.tick - timer_from[ch]) >= hold_ticks) begin
      timer_on[ch] = 1'b0;
      if (u.mode == MODE_PULSE) put_buttons(b, 0, npos);
      else if (u.mode == MODE_DELTA) put_buttons(b, 0, 2);
    end
    r.buttons = 64'(button_state);
    r.level = lvl;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %h, got %h", field, want, got);
  endtask

  task automatic send_update(input update_t u);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, u.tick, u.invert, u.pos_m1, u.first_button, u.mode,
                     u.out_value, u.channel};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_reports.push_back(map_update(u));
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [4:0] ch, input int val, input logic [2:0] mode,
                             input logic [5:0] b, input logic [2:0] pm1, input logic inv,
                             input logic [7:0] tick);
    update_t u;
    u.channel = ch;
    u.out_value = 12'(val);
    u.mode = mode;
    u.first_button = b;
    u.pos_m1 = pm1;
    u.invert = inv;
    u.tick = tick;
    send_update(u);
  endtask

  task automatic wait_reports_done();
    while (expected_reports.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_hold(input logic [7:0] value);
    wait_reports_done();
    repeat (3) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    hold_ticks = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [11:0] pick_value();
    int t;
    case ($urandom_range(0, 4))
      0: t = int'($urandom_range(0, 4095));
      1: t = int'($urandom_range(0, 2048)) - 1024;
      2: t = int'($urandom_range(0, 6)) - 3;
      3: t = ($urandom_range(0, 1) ? 1 : -1) * (1023 + int'($urandom_range(0, 2)));
      default: t = $urandom_range(0, 1) ? 2047 - int'($urandom_range(0, 2))
                                          : -2048 + int'($urandom_range(0, 2));
    endcase
    return 12'(t);
  endfunction

  task automatic new_setups();
    chan_first = $urandom_range(0, CHANNELS - 1);
    chan_span = $urandom_range(1, 8);
    for (int c = 0; c < CHANNELS; c++) begin
      if ($urandom_range(99) < 90)
        setup_mode[c] = 3'($urandom_range(MODE_NORMAL, MODE_COMPANION));
      else
        setup_mode[c] = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      setup_base[c] = 6'($urandom);
      setup_pm1[c] = 3'($urandom);
      setup_inv[c] = 1'($urandom);
    end
  endtask

  task automatic send_random(input int count);
    update_t u;
    int      ch;
    for (int i = 0; i < count; i++) begin
      now_tick += 8'($urandom_range(0, 3));
      ch = (chan_first + int'($urandom_range(0, chan_span - 1))) % CHANNELS;
      if ($urandom_range(99) < 15) begin
        u.channel = 5'($urandom);
        u.out_value = 12'($urandom);
        u.mode = 3'($urandom);
        u.first_button = 6'($urandom);
        u.pos_m1 = 3'($urandom);
        u.invert = 1'($urandom);
        u.tick = 8'($urandom);
      end else begin
        u.channel = 5'(ch);
        u.out_value = pick_value();
        u.mode = setup_mode[ch];
        u.first_button = setup_base[ch];
        u.pos_m1 = setup_pm1[ch];
        u.invert = setup_inv[ch];
        u.tick = now_tick;
      end
      send_update(u);
    end
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_directed_modes();
    send_fields(5'd0, -2048, MODE_NORMAL, 6'd0, 3'd7, 1'b0, 8'd0);
    send_fields(5'd0, 2047, MODE_NORMAL, 6'd0, 3'd7, 1'b0, 8'd1);
    send_fields(5'd1, 0, MODE_NORMAL, 6'd8, 3'd0, 1'b0, 8'd1);
    send_fields(5'd1, 1, MODE_NORMAL, 6'd8, 3'd0, 1'b0, 8'd2);
    send_fields(5'd2, -1024, MODE_SWITCH, 6'd10, 3'd0, 1'b1, 8'd2);
    send_fields(5'd2, 1024, MODE_SWITCH, 6'd10, 3'd0, 1'b1, 8'd3);
    send_fields(5'd2, 1024, MODE_SWITCH, 6'd10, 3'd0, 1'b0, 8'd3);
    send_fields(5'd3, -2048, MODE_DELTA, 6'd12, 3'd0, 1'b0, 8'd4);
    send_fields(5'd3, 2047, MODE_DELTA, 6'd12, 3'd0, 1'b0, 8'd5);
    send_fields(5'd3, 2047, MODE_DELTA, 6'd12, 3'd0, 1'b0, 8'd24);
    send_fields(5'd3, 2047, MODE_DELTA, 6'd12, 3'd0, 1'b0, 8'd25);
    // pulse across the tick wrap
    send_fields(5'd4, 700, MODE_PULSE, 6'd60, 3'd3, 1'b0, 8'd250);
    send_fields(5'd4, 700, MODE_PULSE, 6'd60, 3'd3, 1'b0, 8'd13);
    send_fields(5'd4, 700, MODE_PULSE, 6'd60, 3'd3, 1'b0, 8'd14);
    send_fields(5'd5, -5, MODE_COMPANION, 6'd62, 3'd2, 1'b0, 8'd20);
    send_fields(5'd5, 0, MODE_COMPANION, 6'd62, 3'd2, 1'b0, 8'd21);
    send_fields(5'd5, 500, MODE_COMPANION, 6'd62, 3'd2, 1'b0, 8'd22);
    send_fields(5'd6, 5, MODE_COMPANION, 6'd20, 3'd1, 1'b0, 8'd23);
    // top level lands past the bitmap
    send_fields(5'd7, 2047, MODE_COMPANION, 6'd58, 3'd6, 1'b0, 8'd24);
    send_fields(5'd8, 300, MODE_PULSE, 6'd30, 3'd0, 1'b0, 8'd100);
    // unknown mode while a timer expires
    send_fields(5'd8, 300, MODE_UNUSED_LO, 6'd30, 3'd0, 1'b0, 8'd200);
    send_fields(5'd8, 300, MODE_UNUSED_HI, 6'd30, 3'd0, 1'b0, 8'd201);
    send_fields(5'd31, 2047, MODE_NORMAL, 6'd0, 3'd4, 1'b1, 8'd202);
    send_fields(5'd9, 1023, MODE_NORMAL, 6'd40, 3'd2, 1'b0, 8'd203);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_input_backpressure();
    wait_reports_done();
    new_setups();
    stall_hold = 1'b1;
    send_random(24);
    wait_reports_done();
  endtask

  task automatic test_hold_time(input logic [7:0] value);
    write_hold(value);
    new_setups();
    send_random(PHASE_ITEMS);
    wait_reports_done();
  endtask

  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (stall_hold) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
        stall_hold = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_report
    report_t want;
    report_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.buttons = m_axis_tdata[63:0];
      got.level = m_axis_tdata[68:64];
      got.changed = m_axis_tdata[69];
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result, button bits", '0, got.buttons);
      end else begin
        want = expected_reports.pop_front();
        if (got.buttons !== want.buttons)
          report_mismatch("button bits", want.buttons, got.buttons);
        if (got.level !== want.level)
          report_mismatch("level", 64'(want.level), 64'(got.level));
        if (got.changed !== want.changed)
          report_mismatch("changed", 64'(want.changed), 64'(got.changed));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("channel_to_button_mapper_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      stored_level[c] = '0;
      level_seen[c] = 1'b0;
      timer_on[c] = 1'b0;
      timer_from[c] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct = 12;
    sink_idle_pct = 71;
    test_directed_modes();
    test_input_backpressure();
    test_hold_time(8'd1);
    test_hold_time(8'd255);

    src_idle_pct = 71;
    sink_idle_pct = 12;
    test_hold_time(8'd0);
    test_hold_time(8'($urandom_range(2, 254)));

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_hold_time(HOLD_RESET);

    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("channel_to_button_mapper_core test passed");
    else
      $display("channel_to_button_mapper_core test failed");
    $finish;
  end

endmodule
